FILE: sv/gda_pkg.sv
// Shared types, widths, codes and calendar helpers for the Gregorian date unit.
// No dependencies; imported by the controller, the datapath and the top level.

package gda_pkg;

    // field widths
    localparam int OP_W    = 3;
    localparam int DAY_W   = 5;
    localparam int MON_W   = 4;
    localparam int YEAR_W  = 14;
    localparam int ORD_W   = 2;
    localparam int DIST_W  = 23;
    // walking year can pass the largest input year by one
    localparam int WYEAR_W = YEAR_W + 1;
    // compare width for year + 1 against the year limit
    localparam int YCMP_W  = 17;
    // step count: whole input year range in days fits below 2**24
    localparam int CNT_W   = 24;
    localparam int INC_W   = 9;

    localparam int unsigned DEF_MAX_YEAR = 9999;

    // largest distance magnitude the result field carries
    localparam logic [DIST_W-1:0] DIST_SAT = {1'b0, {(DIST_W-1){1'b1}}};

    // operation codes
    localparam logic [OP_W-1:0] OP_VALIDATE = 3'd0;
    localparam logic [OP_W-1:0] OP_NEXT     = 3'd1;
    localparam logic [OP_W-1:0] OP_PREV     = 3'd2;
    localparam logic [OP_W-1:0] OP_COMPARE  = 3'd3;
    localparam logic [OP_W-1:0] OP_DISTANCE = 3'd4;

    // ordering codes (signed two-bit)
    localparam logic [ORD_W-1:0] ORD_LT = 2'b11;
    localparam logic [ORD_W-1:0] ORD_EQ = 2'b00;
    localparam logic [ORD_W-1:0] ORD_GT = 2'b01;

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_APR = 4'd4;
    localparam logic [MON_W-1:0] MON_JUN = 4'd6;
    localparam logic [MON_W-1:0] MON_SEP = 4'd9;
    localparam logic [MON_W-1:0] MON_NOV = 4'd11;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    // multiplicative inverse of 25 modulo 2**14, and floor((2**14-1)/25)
    localparam logic [YEAR_W-1:0] INV25    = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_dist;
        logic walk_done;
        logic out_free;
    } t_dp_status;

    // 4/100/400 rule; divisibility by 25 by the modular-inverse test
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] prod;
        logic                div25;
        prod  = y * INV25;
        div25 = (prod[YEAR_W-1:0] <= DIV25_LIM);
        return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    // days in month; any code other than the short months counts 31
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            len = 5'd30;
        end else if (m == MON_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end
        return len;
    endfunction

endpackage

FILE: sv/gregorian_date_arithmetic.sv
// Gregorian date unit: validate, next day, previous day, compare, day distance.
// Operands are registered on accept; the result goes to the output register once it is free.
// Distance first runs walk steps (one per whole year skipped, up to two per month crossed).
// Throughput: one item at a time; a new item is taken the cycle after the result
// is written, while that result may still wait in the output register.
// Reset: synchronous active-low i_rst_n clears the controller and output valid.

module gregorian_date_arithmetic
    import gda_pkg::*;
#(
    parameter int unsigned MAX_YEAR = DEF_MAX_YEAR
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [DAY_W-1:0]         i_day_a,
    input  logic [MON_W-1:0]         i_month_a,
    input  logic [YEAR_W-1:0]        i_year_a,
    input  logic [DAY_W-1:0]         i_day_b,
    input  logic [MON_W-1:0]         i_month_b,
    input  logic [YEAR_W-1:0]        i_year_b,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [DAY_W-1:0]         o_result_day,
    output logic [MON_W-1:0]         o_result_month,
    output logic [YEAR_W-1:0]        o_result_year,
    output logic                     o_date_valid,
    output logic signed [ORD_W-1:0]  o_ordering,
    output logic signed [DIST_W-1:0] o_day_distance,
    output logic                     o_range_error
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_sts;

    // sequence load, walk and finish
    gda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // operand, walker and output registers
    gda_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_operation    (i_operation),
        .i_day_a        (i_day_a),
        .i_month_a      (i_month_a),
        .i_year_a       (i_year_a),
        .i_day_b        (i_day_b),
        .i_month_b      (i_month_b),
        .i_year_b       (i_year_b),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_date_valid   (o_date_valid),
        .o_ordering     (o_ordering),
        .o_day_distance (o_day_distance),
        .o_range_error  (o_range_error)
    );

endmodule

FILE: sv/gda_ctrl.sv
// Controller state machine for the Gregorian date unit.
// Depends on gda_pkg for the command and status structs.

module gda_ctrl
    import gda_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_sts,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state r_state;
    t_state n_state;

    // decode next state and datapath commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_sts.is_dist || i_sts.walk_done) begin
                    if (i_sts.out_free) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // take a new item only when idle
    assign o_stall = (r_state != S_IDLE);

endmodule

FILE: sv/gda_datapath.sv
// Datapath of the Gregorian date unit: operand registers, date walker with
// step counter, single-step logic and the output register. Depends on gda_pkg.

module gda_datapath
    import gda_pkg::*;
#(
    parameter int unsigned MAX_YEAR = DEF_MAX_YEAR
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_sts,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [DAY_W-1:0]         i_day_a,
    input  logic [MON_W-1:0]         i_month_a,
    input  logic [YEAR_W-1:0]        i_year_a,
    input  logic [DAY_W-1:0]         i_day_b,
    input  logic [MON_W-1:0]         i_month_b,
    input  logic [YEAR_W-1:0]        i_year_b,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [DAY_W-1:0]         o_result_day,
    output logic [MON_W-1:0]         o_result_month,
    output logic [YEAR_W-1:0]        o_result_year,
    output logic                     o_date_valid,
    output logic signed [ORD_W-1:0]  o_ordering,
    output logic signed [DIST_W-1:0] o_day_distance,
    output logic                     o_range_error
);

    localparam logic [YCMP_W-1:0] MAX_Y = YCMP_W'(MAX_YEAR);

    // operand registers
    logic [OP_W-1:0]    r_op;
    logic [DAY_W-1:0]   r_da;
    logic [MON_W-1:0]   r_ma;
    logic [YEAR_W-1:0]  r_ya;
    logic [ORD_W-1:0]   r_ord;
    logic               r_neg;
    // walker and target
    logic [DAY_W-1:0]   r_wd, n_wd;
    logic [MON_W-1:0]   r_wm, n_wm;
    logic [WYEAR_W-1:0] r_wy, n_wy;
    logic [DAY_W-1:0]   r_td;
    logic [MON_W-1:0]   r_tm;
    logic [WYEAR_W-1:0] r_ty;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_err;
    logic               r_out_valid;

    // input compare
    logic               in_lt, in_gt;
    logic [ORD_W-1:0]   in_ord;

    // walker step logic
    logic               w_leap;
    logic [DAY_W-1:0]   w_len;
    logic [DAY_W-1:0]   w_tgt;
    logic [YCMP_W-1:0]  w_yinc;
    logic               w_year_over;
    logic               w_before;
    logic               w_year_jump;
    logic               w_err;
    logic [INC_W-1:0]   w_inc;

    // single step of A
    logic               a_leap;
    logic [DAY_W-1:0]   a_len;
    logic [MON_W-1:0]   a_mdec;
    logic               a_valid;
    logic [DAY_W-1:0]   s_d;
    logic [MON_W-1:0]   s_m;
    logic [YEAR_W-1:0]  s_y;
    logic               s_err;

    // distance result
    logic [DIST_W-1:0]  dist_mag;
    logic [DIST_W-1:0]  dist_val;

    // order the incoming dates by year, month, day
    always_comb begin
        in_lt = (i_year_a < i_year_b) ||
                ((i_year_a == i_year_b) && ((i_month_a < i_month_b) ||
                 ((i_month_a == i_month_b) && (i_day_a < i_day_b))));
        in_gt = (i_year_a > i_year_b) ||
                ((i_year_a == i_year_b) && ((i_month_a > i_month_b) ||
                 ((i_month_a == i_month_b) && (i_day_a > i_day_b))));
        in_ord = in_lt ? ORD_LT : (in_gt ? ORD_GT : ORD_EQ);
    end

    // one walk iteration: whole year, fill of month, or month boundary
    always_comb begin
        n_wd        = r_wd;
        n_wm        = r_wm;
        n_wy        = r_wy;
        w_inc       = '0;
        w_err       = 1'b0;
        w_tgt       = '0;
        w_leap      = is_leap(r_wy[YEAR_W-1:0]);
        w_len       = month_len(r_wm, w_leap);
        w_yinc      = {{(YCMP_W-WYEAR_W){1'b0}}, r_wy} + YCMP_W'(1);
        w_year_over = (w_yinc > MAX_Y);
        w_before    = (r_wy < r_ty) ||
                      ((r_wy == r_ty) && ((r_wm < r_tm) ||
                       ((r_wm == r_tm) && (r_wd < r_td))));
        w_year_jump = (r_wm == MON_JAN) && (r_wd == 5'd1) && (r_wy < r_ty);
        if (w_year_jump) begin
            if (w_year_over) begin
                w_err = 1'b1;
            end else begin
                w_inc = w_leap ? 9'd366 : 9'd365;
                n_wy  = r_wy + WYEAR_W'(1);
            end
        end else if (r_wd < w_len) begin
            w_tgt = ((r_wy == r_ty) && (r_wm == r_tm) && (r_td < w_len)) ? r_td : w_len;
            w_inc = {{(INC_W-DAY_W){1'b0}}, w_tgt - r_wd};
            n_wd  = w_tgt;
        end else if (r_wm < MON_DEC) begin
            w_inc = 9'd1;
            n_wd  = 5'd1;
            n_wm  = r_wm + MON_W'(1);
        end else if (w_year_over) begin
            w_err = 1'b1;
        end else begin
            w_inc = 9'd1;
            n_wd  = 5'd1;
            n_wm  = MON_JAN;
            n_wy  = r_wy + WYEAR_W'(1);
        end
    end

    // next or previous day of A, and validity of A
    always_comb begin
        a_leap  = is_leap(r_ya);
        a_len   = month_len(r_ma, a_leap);
        a_mdec  = r_ma - MON_W'(1);
        a_valid = (r_ya != '0) && (r_ma >= MON_JAN) && (r_ma <= MON_DEC) &&
                  (r_da != '0) && (r_da <= a_len);
        s_d     = r_da;
        s_m     = r_ma;
        s_y     = r_ya;
        s_err   = 1'b0;
        if (r_op == OP_NEXT) begin
            if (r_da < a_len) begin
                s_d = r_da + DAY_W'(1);
            end else if (r_ma < MON_DEC) begin
                s_d = 5'd1;
                s_m = r_ma + MON_W'(1);
            end else if (({{(YCMP_W-YEAR_W){1'b0}}, r_ya} + YCMP_W'(1)) > MAX_Y) begin
                s_err = 1'b1;
            end else begin
                s_d = 5'd1;
                s_m = MON_JAN;
                s_y = r_ya + YEAR_W'(1);
            end
        end else begin
            if (r_da != 5'd1) begin
                s_d = r_da - DAY_W'(1);
            end else if (r_ma != MON_JAN) begin
                s_m = a_mdec;
                s_d = month_len(a_mdec, a_leap);
            end else if (r_ya < 14'd2) begin
                s_err = 1'b1;
            end else begin
                s_m = MON_DEC;
                s_d = 5'd31;
                s_y = r_ya - YEAR_W'(1);
            end
        end
    end

    // saturate and sign the step count; zero on a range error
    always_comb begin
        if (r_cnt > {{(CNT_W-DIST_W){1'b0}}, DIST_SAT}) begin
            dist_mag = DIST_SAT;
        end else begin
            dist_mag = r_cnt[DIST_W-1:0];
        end
        if (r_err) begin
            dist_val = '0;
        end else if (r_neg) begin
            dist_val = '0 - dist_mag;
        end else begin
            dist_val = dist_mag;
        end
    end

    // capture operands; walk from the earlier date toward the later one
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_da  <= i_day_a;
            r_ma  <= i_month_a;
            r_ya  <= i_year_a;
            r_ord <= in_ord;
            r_neg <= in_gt;
            r_cnt <= '0;
            if (in_gt) begin
                r_wd <= i_day_b;
                r_wm <= i_month_b;
                r_wy <= {1'b0, i_year_b};
                r_td <= i_day_a;
                r_tm <= i_month_a;
                r_ty <= {1'b0, i_year_a};
            end else begin
                r_wd <= i_day_a;
                r_wm <= i_month_a;
                r_wy <= {1'b0, i_year_a};
                r_td <= i_day_b;
                r_tm <= i_month_b;
                r_ty <= {1'b0, i_year_b};
            end
        end else if (i_cmd.step && !w_err) begin
            r_wd  <= n_wd;
            r_wm  <= n_wm;
            r_wy  <= n_wy;
            r_cnt <= r_cnt + CNT_W'(w_inc);
        end
    end

    // hold the range flag of the walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (i_cmd.load) begin
            r_err <= 1'b0;
        end else if (i_cmd.step && w_err) begin
            r_err <= 1'b1;
        end
    end

    // output valid: set on finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_date_valid   <= a_valid;
            o_ordering     <= r_ord;
            o_result_day   <= '0;
            o_result_month <= '0;
            o_result_year  <= '0;
            o_day_distance <= '0;
            o_range_error  <= 1'b0;
            case (r_op)
                OP_NEXT, OP_PREV: begin
                    o_result_day   <= s_err ? r_da : s_d;
                    o_result_month <= s_err ? r_ma : s_m;
                    o_result_year  <= s_err ? r_ya : s_y;
                    o_range_error  <= s_err;
                end
                OP_DISTANCE: begin
                    o_day_distance <= dist_val;
                    o_range_error  <= r_err;
                end
                default: begin
                    o_range_error <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sts.is_dist   = (r_op == OP_DISTANCE);
    assign o_sts.walk_done = r_err || !w_before;
    assign o_sts.out_free  = !r_out_valid || !i_stall;

endmodule

FILE: test/gda_result_checker.sv
// Result checker for the Gregorian date unit: predicts each accepted item and
// compares every accepted result with the oldest prediction. Depends on gda_pkg.

module gda_result_checker
    import gda_pkg::*;
#(
    parameter int unsigned MAX_YEAR = DEF_MAX_YEAR
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_in_valid,
    input  logic                     i_in_stall,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [DAY_W-1:0]         i_day_a,
    input  logic [MON_W-1:0]         i_month_a,
    input  logic [YEAR_W-1:0]        i_year_a,
    input  logic [DAY_W-1:0]         i_day_b,
    input  logic [MON_W-1:0]         i_month_b,
    input  logic [YEAR_W-1:0]        i_year_b,
    // result channel
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  logic [DAY_W-1:0]         i_result_day,
    input  logic [MON_W-1:0]         i_result_month,
    input  logic [YEAR_W-1:0]        i_result_year,
    input  logic                     i_date_valid,
    input  logic signed [ORD_W-1:0]  i_ordering,
    input  logic signed [DIST_W-1:0] i_day_distance,
    input  logic                     i_range_error,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic              date_ok;
        logic [ORD_W-1:0]  ordering;
        logic [DIST_W-1:0] distance;
        logic              range_err;
    } t_day_result;

    t_day_result expected_days[$];
    int          mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic bit leap_rule(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_of(input int unsigned m, input int unsigned y);
        if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) return 30;
        if (m == MON_FEB) return leap_rule(y) ? 29 : 28;
        return 31;
    endfunction

    // year first, then month, then day, on the raw fields
    function automatic int date_rank(input int unsigned d1, m1, y1, d2, m2, y2);
        if (y1 != y2) return (y1 < y2) ? -1 : 1;
        if (m1 != m2) return (m1 < m2) ? -1 : 1;
        if (d1 != d2) return (d1 < d2) ? -1 : 1;
        return 0;
    endfunction

    // advance one day; a set return means the year limit was hit, date kept
    function automatic bit day_after(inout int unsigned d, m, y);
        if (d < days_of(m, y)) begin
            d = d + 1;
            return 1'b0;
        end
        if (m < MON_DEC) begin
            d = 1;
            m = m + 1;
            return 1'b0;
        end
        if (y + 1 > MAX_YEAR) return 1'b1;
        d = 1;
        m = MON_JAN;
        y = y + 1;
        return 1'b0;
    endfunction

    // back one day; day and month wrap at their field widths
    function automatic bit day_before(inout int unsigned d, m, y);
        if (d != 1) begin
            d = (d - 1) & ((1 << DAY_W) - 1);
            return 1'b0;
        end
        if (m != MON_JAN) begin
            m = (m - 1) & ((1 << MON_W) - 1);
            d = days_of(m, y);
            return 1'b0;
        end
        if (y < 2) return 1'b1;
        m = MON_DEC;
        d = 31;
        y = y - 1;
        return 1'b0;
    endfunction

    // walk from the first date until it no longer lies before the second
    function automatic int unsigned days_between(input int unsigned d1, m1, y1, d2, m2, y2,
                                                 output bit err);
        int unsigned total;
        int unsigned len;
        int unsigned stop;
        total = 0;
        err   = 1'b0;
        while (date_rank(d1, m1, y1, d2, m2, y2) < 0) begin
            if (m1 == MON_JAN && d1 == 1 && y1 < y2) begin
                // skip a whole year at once
                if (y1 + 1 > MAX_YEAR) begin
                    err = 1'b1;
                    return 0;
                end
                total = total + (leap_rule(y1) ? 366 : 365);
                y1    = y1 + 1;
            end else begin
                len = days_of(m1, y1);
                if (d1 < len) begin
                    // run to month end, or to the target day in the target month
                    stop = len;
                    if (y1 == y2 && m1 == m2 && d2 < len) stop = d2;
                    total = total + (stop - d1);
                    d1    = stop;
                end else if (day_after(d1, m1, y1)) begin
                    err = 1'b1;
                    return 0;
                end else begin
                    total = total + 1;
                end
            end
        end
        return total;
    endfunction

    function automatic t_day_result predict_day_op(input logic [OP_W-1:0] op,
                                                   input int unsigned da, ma, ya,
                                                   input int unsigned db, mb, yb);
        t_day_result r;
        int unsigned rd, rm, ry, span;
        int          rank;
        bit          err;
        r    = '0;
        err  = 1'b0;
        rank = date_rank(da, ma, ya, db, mb, yb);
        r.date_ok  = (ya >= 1) && (ma >= 1) && (ma <= 12) && (da >= 1) &&
                     (da <= days_of(ma, ya));
        r.ordering = (rank < 0) ? ORD_LT : ((rank > 0) ? ORD_GT : ORD_EQ);
        case (op)
            OP_NEXT, OP_PREV: begin
                rd = da;
                rm = ma;
                ry = ya;
                if (op == OP_NEXT) begin
                    err = day_after(rd, rm, ry);
                end else begin
                    err = day_before(rd, rm, ry);
                end
                // out of range: hand back date A untouched
                if (err) begin
                    rd = da;
                    rm = ma;
                    ry = ya;
                end
                r.day   = rd[DAY_W-1:0];
                r.month = rm[MON_W-1:0];
                r.year  = ry[YEAR_W-1:0];
            end
            OP_DISTANCE: begin
                if (rank > 0) begin
                    span = days_between(db, mb, yb, da, ma, ya, err);
                end else begin
                    span = days_between(da, ma, ya, db, mb, yb, err);
                end
                if (span > 32'(DIST_SAT)) span = 32'(DIST_SAT);
                if (rank > 0) begin
                    r.distance = DIST_W'(0 - span);
                end else begin
                    r.distance = DIST_W'(span);
                end
            end
            default: begin
            end
        endcase
        r.range_err = err;
        return r;
    endfunction

    function automatic void report_mismatch(input string what, input longint want,
                                            input longint got);
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        end
    endfunction

    // retire results first so a fresh prediction never covers a missing one
    always @(posedge i_clk) begin
        t_day_result want;
        if (!i_rst_n) begin
            expected_days.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_days.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("%0t: result arrived with no item pending", $realtime);
                    end
                end else begin
                    want = expected_days.pop_front();
                    if (i_result_day != want.day) begin
                        report_mismatch("result_day", longint'(want.day),
                                        longint'(i_result_day));
                    end
                    if (i_result_month != want.month) begin
                        report_mismatch("result_month", longint'(want.month),
                                        longint'(i_result_month));
                    end
                    if (i_result_year != want.year) begin
                        report_mismatch("result_year", longint'(want.year),
                                        longint'(i_result_year));
                    end
                    if (i_date_valid != want.date_ok) begin
                        report_mismatch("date_valid", longint'(want.date_ok),
                                        longint'(i_date_valid));
                    end
                    if (i_ordering != want.ordering) begin
                        report_mismatch("ordering", longint'($signed(want.ordering)),
                                        longint'(i_ordering));
                    end
                    if (i_day_distance != want.distance) begin
                        report_mismatch("day_distance", longint'($signed(want.distance)),
                                        longint'(i_day_distance));
                    end
                    if (i_range_error != want.range_err) begin
                        report_mismatch("range_error", longint'(want.range_err),
                                        longint'(i_range_error));
                    end
                    o_checked <= o_checked + 1;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_days.push_back(predict_day_op(i_operation, 32'(i_day_a),
                                                       32'(i_month_a), 32'(i_year_a),
                                                       32'(i_day_b), 32'(i_month_b),
                                                       32'(i_year_b)));
            end
            o_pending <= expected_days.size();
        end
    end

endmodule

FILE: test/gregorian_date_arithmetic_tb.sv
// Top of the Gregorian date unit testbench: clock, reset, item stimulus and verdict.
// Depends on gda_pkg, gregorian_date_arithmetic and gda_result_checker.

module gregorian_date_arithmetic_tb
    import gda_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 5000000;
    localparam int RANDOM_ITEMS = 75;
    localparam int QUIET_TAIL   = 20;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [OP_W-1:0]          i_operation;
    logic [DAY_W-1:0]         i_day_a;
    logic [MON_W-1:0]         i_month_a;
    logic [YEAR_W-1:0]        i_year_a;
    logic [DAY_W-1:0]         i_day_b;
    logic [MON_W-1:0]         i_month_b;
    logic [YEAR_W-1:0]        i_year_b;
    logic                     o_valid;
    logic                     i_stall;
    logic [DAY_W-1:0]         o_result_day;
    logic [MON_W-1:0]         o_result_month;
    logic [YEAR_W-1:0]        o_result_year;
    logic                     o_date_valid;
    logic signed [ORD_W-1:0]  o_ordering;
    logic signed [DIST_W-1:0] o_day_distance;
    logic                     o_range_error;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int op_tally[8];
    bit quiet = 1'b0;

    gregorian_date_arithmetic u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_day_a        (i_day_a),
        .i_month_a      (i_month_a),
        .i_year_a       (i_year_a),
        .i_day_b        (i_day_b),
        .i_month_b      (i_month_b),
        .i_year_b       (i_year_b),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_date_valid   (o_date_valid),
        .o_ordering     (o_ordering),
        .o_day_distance (o_day_distance),
        .o_range_error  (o_range_error)
    );

    gda_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_operation    (i_operation),
        .i_day_a        (i_day_a),
        .i_month_a      (i_month_a),
        .i_year_a       (i_year_a),
        .i_day_b        (i_day_b),
        .i_month_b      (i_month_b),
        .i_year_b       (i_year_b),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_result_day   (o_result_day),
        .i_result_month (o_result_month),
        .i_result_year  (o_result_year),
        .i_date_valid   (o_date_valid),
        .i_ordering     (o_ordering),
        .i_day_distance (o_day_distance),
        .i_range_error  (o_range_error),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop for a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[gregorian_date_arithmetic] ERROR");
            $finish;
        end
    end

    // result side: random stall bursts, none once the quiet tail starts
    initial begin
        i_stall <= 1'b0;
        forever begin
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // present one item, hold it until accepted, then maybe leave a gap
    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic [DAY_W-1:0] da, input logic [MON_W-1:0] ma,
                             input logic [YEAR_W-1:0] ya,
                             input logic [DAY_W-1:0] db, input logic [MON_W-1:0] mb,
                             input logic [YEAR_W-1:0] yb);
        i_operation <= op;
        i_day_a     <= da;
        i_month_a   <= ma;
        i_year_a    <= ya;
        i_day_b     <= db;
        i_month_b   <= mb;
        i_year_b    <= yb;
        i_valid     <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        op_tally[op] = op_tally[op] + 1;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // mostly well-formed dates biased to month ends and leap-rule years
    task automatic make_date(output logic [DAY_W-1:0] d, output logic [MON_W-1:0] m,
                             output logic [YEAR_W-1:0] y);
        int unsigned edge_years[11] = '{1, 2, 4, 100, 400, 1600, 1900, 2000, 2100,
                                        9998, 9999};
        int unsigned len;
        if ($urandom_range(0, 4) == 0) begin
            d = DAY_W'($urandom_range(0, 31));
            m = MON_W'($urandom_range(0, 15));
            y = YEAR_W'($urandom_range(0, 9999));
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                y = YEAR_W'(edge_years[$urandom_range(0, 10)]);
            end else begin
                y = YEAR_W'($urandom_range(1, 9999));
            end
            m   = MON_W'($urandom_range(1, 12));
            len = 32'(month_len(m, is_leap(y)));
            case ($urandom_range(0, 3))
                0: d = 1;
                1: d = DAY_W'(len);
                default: d = DAY_W'($urandom_range(1, len));
            endcase
        end
    endtask

    initial begin
        logic [OP_W-1:0]   op;
        logic [DAY_W-1:0]  da, db;
        logic [MON_W-1:0]  ma, mb;
        logic [YEAR_W-1:0] ya, yb;
        int                pick;
        int                near_year;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_operation <= OP_VALIDATE;
        i_day_a     <= '0;
        i_month_a   <= '0;
        i_year_a    <= '0;
        i_day_b     <= '0;
        i_month_b   <= '0;
        i_year_b    <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes and leap-rule validation
        send_item(OP_VALIDATE, 0, 0, 0, 31, 15, 9999);
        send_item(OP_VALIDATE, 31, 15, 9999, 0, 0, 0);
        send_item(OP_VALIDATE, 29, 2, 1900, 1, 1, 1);
        send_item(OP_VALIDATE, 29, 2, 2000, 29, 2, 2000);
        // next day: leap day, top of range, year and month rollover, malformed
        send_item(OP_NEXT, 28, 2, 2004, 1, 1, 1);
        send_item(OP_NEXT, 31, 12, 9999, 1, 1, 1);
        send_item(OP_NEXT, 31, 12, 1999, 1, 1, 2000);
        send_item(OP_NEXT, 30, 4, 2023, 30, 4, 2023);
        send_item(OP_NEXT, 31, 14, 5, 1, 1, 6);
        send_item(OP_NEXT, 5, 0, 0, 5, 0, 0);
        // previous day: bottom of range, century non-leap, wraps of day and month
        send_item(OP_PREV, 1, 1, 1, 1, 1, 1);
        send_item(OP_PREV, 1, 3, 2100, 28, 2, 2100);
        send_item(OP_PREV, 1, 1, 2000, 31, 12, 1999);
        send_item(OP_PREV, 0, 7, 100, 1, 7, 100);
        send_item(OP_PREV, 1, 0, 50, 1, 1, 50);
        // ordering
        send_item(OP_COMPARE, 15, 6, 1776, 15, 6, 1776);
        send_item(OP_COMPARE, 14, 6, 1776, 15, 6, 1776);
        send_item(OP_COMPARE, 1, 1, 1777, 31, 12, 1776);
        // distance: full span both ways, range limit, zero, within a year
        send_item(OP_DISTANCE, 1, 1, 1, 31, 12, 9999);
        send_item(OP_DISTANCE, 31, 12, 9999, 1, 1, 1);
        send_item(OP_DISTANCE, 31, 12, 9999, 1, 13, 9999);
        send_item(OP_DISTANCE, 29, 2, 2024, 29, 2, 2024);
        send_item(OP_DISTANCE, 15, 3, 2023, 10, 4, 2023);
        // unused codes behave as validate
        send_item(3'd5, 31, 12, 9999, 1, 1, 1);
        send_item(3'd7, 1, 1, 1, 31, 12, 9999);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) drain_results();
            if (n == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
            make_date(da, ma, ya);
            make_date(db, mb, yb);
            pick = int'($urandom_range(0, 99));
            if (pick < 15) begin
                op = OP_VALIDATE;
            end else if (pick < 35) begin
                op = OP_NEXT;
            end else if (pick < 55) begin
                op = OP_PREV;
            end else if (pick < 70) begin
                op = OP_COMPARE;
            end else if (pick < 95) begin
                op = OP_DISTANCE;
            end else begin
                op = OP_W'($urandom_range(5, 7));
            end
            // compare: often equal or near; distance: mostly within a few years
            if (op == OP_COMPARE && $urandom_range(0, 1) == 0) begin
                db = da;
                mb = ma;
                yb = ya;
                if ($urandom_range(0, 1) == 0) db = db ^ DAY_W'($urandom_range(1, 3));
            end else if ((op == OP_COMPARE || op == OP_DISTANCE) &&
                         $urandom_range(0, 9) != 0) begin
                near_year = int'(ya) + int'($urandom_range(0, 4)) - 2;
                if (near_year < 0) near_year = 0;
                if (near_year > 9999) near_year = 9999;
                yb = YEAR_W'(near_year);
            end
            send_item(op, da, ma, ya, db, mb, yb);
        end

        drain_results();
        repeat (20) @(posedge i_clk);

        $display("Covered %0d items: %0d validate, %0d next, %0d previous, %0d compare,",
                 op_tally.sum(), op_tally[OP_VALIDATE], op_tally[OP_NEXT],
                 op_tally[OP_PREV], op_tally[OP_COMPARE]);
        $display("%0d distance, %0d unused codes; %0d results checked, %0d mismatches",
                 op_tally[OP_DISTANCE], op_tally[5] + op_tally[6] + op_tally[7],
                 checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[gregorian_date_arithmetic] OK");
        end else begin
            $display("[gregorian_date_arithmetic] ERROR");
        end
        $finish;
    end

endmodule
